// ----- design/wtv_pkg.sv -----
// Shared types and constants for the word tokenizer.
`default_nettype none
package wtv_pkg;
	localparam int MAX_TOKEN_CHARS = 49;
	localparam int VOCAB_DEPTH = 1024;
	localparam int LEN_W = 6;
	localparam int ID_W = 10;
	localparam int ENT_W = 11;
	localparam int CHAR_W = 8;
	localparam int POS_W = 6;
	localparam int ADDR_W = 16;
	localparam int VCHARS_DEPTH = VOCAB_DEPTH * MAX_TOKEN_CHARS;

	localparam logic [7:0] CH_QMARK = 8'h3F;
	localparam logic [7:0] CH_HYPHEN = 8'h2D;
	localparam logic [7:0] CH_APOS = 8'h27;
	localparam logic [7:0] CH_NL = 8'h0A;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_PERIOD = 8'h2E;
	localparam logic [7:0] CH_BANG = 8'h21;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_ENTRY,
		ST_LEN,
		ST_CMP,
		ST_CMPW,
		ST_COPY,
		ST_EMIT,
		ST_WAIT
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic take_byte;   // latch input, update word
		logic sel_punct;   // current token is the one-char punctuation
		logic clr_entry;   // restart entry scan at 0
		logic next_entry;  // advance entry
		logic rd_len;      // read length of current entry
		logic clr_pos;
		logic next_pos;
		logic rd_char;     // issue char reads at pos
		logic wr_char;     // copy token char into vocab
		logic wr_len;      // write new length, bump entries
		logic set_found;
		logic set_new;
		logic set_full;
		logic load_out;
		logic last;
		logic clr_word;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_word;
		logic is_punct;
		logic eot;
		logic word_nz;
		logic entry_last;  // current entry is last used one
		logic room;        // vocabulary has a free entry
		logic len_eq;
		logic pos_last;    // pos is last char of token
		logic char_eq;
		logic out_busy;
	} sts_t;

	function automatic logic is_word_byte(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
			c == CH_HYPHEN || c == CH_APOS;
	endfunction

	function automatic logic is_punct_byte(input logic [7:0] c);
		return c == CH_NL || c == CH_COMMA || c == CH_PERIOD || c == CH_BANG ||
			c == CH_QMARK;
	endfunction
endpackage
`default_nettype wire

// ----- design/word_tokenizer_vocab_ids.sv -----
// Top level of the word tokenizer with a growing vocabulary.
// The block takes one byte at a time and stalls its input until that byte's tokens are done.
// Per token it decodes the byte, scans the vocabulary entries comparing lengths,
// compares characters on a length match, copies characters into a new entry when
// none matches and there is room, and loads the result, waiting out output stalls.
// Reset (arst_n) empties the word and leaves one entry, "?".
`default_nettype none
module word_tokenizer_vocab_ids (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_stall,
	input  wire logic [7:0]                text_char,
	input  wire logic                      end_of_text,
	output logic                           out_valid,
	input  wire logic                      out_stall,
	output logic [wtv_pkg::ID_W-1:0]       token_id,
	output logic                           new_entry,
	output logic                           table_full,
	output logic                           last_of_run
);
	wtv_pkg::cmd_t cmd;
	wtv_pkg::sts_t sts;

	wtv_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.sts(sts), .cmd(cmd)
	);

	wtv_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .text_char(text_char), .end_of_text(end_of_text),
		.cmd(cmd), .sts(sts), .out_stall(out_stall), .out_valid(out_valid),
		.token_id(token_id), .new_entry(new_entry), .table_full(table_full),
		.last_of_run(last_of_run)
	);
endmodule
`default_nettype wire

// ----- design/wtv_ram.sv -----
// Generic single-port-write, one-read RAM with registered read.
`default_nettype none
module wtv_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ----- design/wtv_datapath.sv -----
// Datapath: word buffer, vocabulary memories, scan counters, output register.
`default_nettype none
module wtv_datapath (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic [7:0]                text_char,
	input  wire logic                      end_of_text,
	input  wire wtv_pkg::cmd_t             cmd,
	output wtv_pkg::sts_t                  sts,
	input  wire logic                      out_stall,
	output logic                           out_valid,
	output logic [wtv_pkg::ID_W-1:0]       token_id,
	output logic                           new_entry,
	output logic                           table_full,
	output logic                           last_of_run
);
	localparam int WB_AW = $clog2(wtv_pkg::MAX_TOKEN_CHARS);
	localparam int VL_AW = $clog2(wtv_pkg::VOCAB_DEPTH);
	localparam int VC_AW = $clog2(wtv_pkg::VCHARS_DEPTH);

	logic [7:0] ch_q;
	logic eot_q;
	logic [wtv_pkg::LEN_W-1:0] wlen_q;
	logic [wtv_pkg::ENT_W-1:0] used_q;
	logic [VL_AW-1:0] ent_q;
	logic [VC_AW-1:0] base_q;
	logic [wtv_pkg::POS_W-1:0] pos_q;
	logic found_q, new_q, full_q;
	logic [7:0] lc;
	logic wb_we;
	logic [7:0] wb_rd, vc_rd;
	logic [wtv_pkg::LEN_W-1:0] vl_rd, tok_len, vl_wd;
	logic [7:0] tok_ch;
	logic [VC_AW-1:0] vc_addr;
	logic [VL_AW-1:0] vl_raddr;
	logic vl_we;
	logic [7:0] vc_wd;

	assign lc = (text_char >= 8'h41 && text_char <= 8'h5A) ? text_char + 8'h20 : text_char;
	assign wb_we = cmd.take_byte && wtv_pkg::is_word_byte(text_char) &&
		wlen_q < wtv_pkg::LEN_W'(wtv_pkg::MAX_TOKEN_CHARS);

	wtv_ram #(.WIDTH(8), .DEPTH(wtv_pkg::MAX_TOKEN_CHARS)) u_wb (
		.clk(clk), .we(wb_we), .waddr(WB_AW'(wlen_q)), .wdata(lc),
		.raddr(WB_AW'(pos_q)), .rdata(wb_rd)
	);

	// entry 0 ("?") lives in flops; RAM slot 0 is never used
	assign vc_addr = VC_AW'(base_q + VC_AW'(pos_q));
	assign vc_wd = tok_ch;
	wtv_ram #(.WIDTH(8), .DEPTH(wtv_pkg::VCHARS_DEPTH)) u_vc (
		.clk(clk), .we(cmd.wr_char), .waddr(vc_addr), .wdata(vc_wd),
		.raddr(vc_addr), .rdata(vc_rd)
	);

	assign vl_raddr = ent_q;
	assign vl_we = cmd.wr_len;
	assign vl_wd = tok_len;
	wtv_ram #(.WIDTH(wtv_pkg::LEN_W), .DEPTH(wtv_pkg::VOCAB_DEPTH)) u_vl (
		.clk(clk), .we(vl_we), .waddr(VL_AW'(used_q)), .wdata(vl_wd),
		.raddr(vl_raddr), .rdata(vl_rd)
	);

	assign tok_len = cmd.sel_punct ? wtv_pkg::LEN_W'(1) : wlen_q;
	assign tok_ch = cmd.sel_punct ? ch_q : wb_rd;

	logic [7:0] ent_ch;
	logic [wtv_pkg::LEN_W-1:0] ent_len;
	logic zero_q;
	assign ent_ch = zero_q ? wtv_pkg::CH_QMARK : vc_rd;
	assign ent_len = zero_q ? wtv_pkg::LEN_W'(1) : vl_rd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlen_q <= '0;
			used_q <= wtv_pkg::ENT_W'(1);
			out_valid <= 1'b0;
		end else begin
			if (cmd.clr_word)
				wlen_q <= '0;
			else if (wb_we)
				wlen_q <= wlen_q + 1'b1;
			if (cmd.wr_len)
				used_q <= used_q + 1'b1;
			if (cmd.load_out)
				out_valid <= 1'b1;
			else if (!out_stall)
				out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_byte) begin
			ch_q <= text_char;
			eot_q <= end_of_text;
		end
		// append goes to the slot right after the last entry scanned
		if (cmd.wr_len) begin
			ent_q <= VL_AW'(used_q);
			base_q <= base_q + VC_AW'(wtv_pkg::MAX_TOKEN_CHARS);
		end else if (cmd.clr_entry) begin
			ent_q <= '0;
			base_q <= '0;
			zero_q <= 1'b1;
		end else if (cmd.next_entry) begin
			ent_q <= ent_q + 1'b1;
			base_q <= base_q + VC_AW'(wtv_pkg::MAX_TOKEN_CHARS);
			zero_q <= 1'b0;
		end
		if (cmd.clr_pos)
			pos_q <= '0;
		else if (cmd.next_pos)
			pos_q <= pos_q + 1'b1;
		if (cmd.set_found)
			found_q <= 1'b1;
		else if (cmd.clr_entry)
			found_q <= 1'b0;
		if (cmd.set_new)
			new_q <= 1'b1;
		else if (cmd.clr_entry)
			new_q <= 1'b0;
		if (cmd.set_full)
			full_q <= 1'b1;
		else if (cmd.clr_entry)
			full_q <= 1'b0;
		if (cmd.load_out) begin
			token_id <= (found_q || new_q) ? ent_q : '0;
			new_entry <= new_q;
			table_full <= full_q;
			last_of_run <= cmd.last;
		end
	end

	assign sts.is_word = wtv_pkg::is_word_byte(ch_q);
	assign sts.is_punct = wtv_pkg::is_punct_byte(ch_q);
	assign sts.eot = eot_q;
	assign sts.word_nz = wlen_q != '0;
	assign sts.entry_last = wtv_pkg::ENT_W'(ent_q) == used_q - 1'b1;
	assign sts.room = used_q < wtv_pkg::ENT_W'(wtv_pkg::VOCAB_DEPTH);
	assign sts.len_eq = ent_len == tok_len;
	assign sts.pos_last = pos_q == tok_len - 1'b1;
	assign sts.char_eq = ent_ch == tok_ch;
	assign sts.out_busy = out_valid && out_stall;

	property p_full_no_new;
		@(posedge clk) disable iff (!arst_n) out_valid |-> !(new_entry && table_full);
	endproperty
	assert property (p_full_no_new) else $error("new and full together");

	property p_used_bound;
		@(posedge clk) disable iff (!arst_n)
			used_q >= wtv_pkg::ENT_W'(1) && used_q <= wtv_pkg::ENT_W'(wtv_pkg::VOCAB_DEPTH);
	endproperty
	assert property (p_used_bound) else $error("entry count out of range");

	property p_wlen_bound;
		@(posedge clk) disable iff (!arst_n)
			wlen_q <= wtv_pkg::LEN_W'(wtv_pkg::MAX_TOKEN_CHARS);
	endproperty
	assert property (p_wlen_bound) else $error("word length overflow");

	property p_no_load_busy;
		@(posedge clk) disable iff (!arst_n) cmd.load_out |-> !(out_valid && out_stall);
	endproperty
	assert property (p_no_load_busy) else $error("output overwritten");
endmodule
`default_nettype wire

// ----- design/wtv_ctrl.sv -----
// Controller state machine: sequences tokens, lookups, appends and results.
`default_nettype none
module wtv_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire wtv_pkg::sts_t sts,
	output wtv_pkg::cmd_t      cmd
);
	wtv_pkg::state_t state_q, state_d;
	logic punct_q, punct_d;   // working on the punctuation token
	logic last_q, last_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wtv_pkg::ST_IDLE;
			punct_q <= 1'b0;
			last_q <= 1'b0;
		end else begin
			state_q <= state_d;
			punct_q <= punct_d;
			last_q <= last_d;
		end
	end

	always_comb begin
		state_d = state_q;
		punct_d = punct_q;
		last_d = last_q;
		cmd = '0;
		cmd.sel_punct = punct_q;
		in_stall = 1'b1;
		case (state_q)
			wtv_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.take_byte = 1'b1;
					state_d = wtv_pkg::ST_INIT;
				end
			end
			// decide which token(s) the byte makes
			wtv_pkg::ST_INIT: begin
				cmd.clr_entry = 1'b1;
				cmd.clr_pos = 1'b1;
				if (sts.is_word) begin
					if (sts.eot) begin
						punct_d = 1'b0;
						last_d = 1'b1;
						state_d = wtv_pkg::ST_ENTRY;
					end else
						state_d = wtv_pkg::ST_IDLE;
				end else if (sts.word_nz) begin
					punct_d = 1'b0;
					last_d = !sts.is_punct;
					state_d = wtv_pkg::ST_ENTRY;
				end else if (sts.is_punct) begin
					punct_d = 1'b1;
					last_d = 1'b1;
					cmd.sel_punct = 1'b1;
					state_d = wtv_pkg::ST_ENTRY;
				end else
					state_d = wtv_pkg::ST_IDLE;
			end
			wtv_pkg::ST_ENTRY: begin
				state_d = wtv_pkg::ST_LEN;
			end
			wtv_pkg::ST_LEN: begin
				// length and char at pos 0 valid here
				if (sts.len_eq)
					state_d = wtv_pkg::ST_CMP;
				else if (sts.entry_last)
					state_d = wtv_pkg::ST_COPY;
				else begin
					cmd.next_entry = 1'b1;
					state_d = wtv_pkg::ST_ENTRY;
				end
				if (state_d == wtv_pkg::ST_COPY) begin
					if (sts.room) begin
						cmd.clr_entry = 1'b1;
						cmd.clr_pos = 1'b1;
						cmd.wr_len = 1'b1;
						cmd.set_new = 1'b1;
					end else begin
						cmd.clr_entry = 1'b1;
						cmd.set_full = 1'b1;
						state_d = wtv_pkg::ST_EMIT;
					end
				end
			end
			wtv_pkg::ST_CMP: begin
				if (!sts.char_eq) begin
					cmd.clr_pos = 1'b1;
					if (sts.entry_last) begin
						if (sts.room) begin
							cmd.clr_entry = 1'b1;
							cmd.wr_len = 1'b1;
							cmd.set_new = 1'b1;
							state_d = wtv_pkg::ST_COPY;
						end else begin
							cmd.clr_entry = 1'b1;
							cmd.set_full = 1'b1;
							state_d = wtv_pkg::ST_EMIT;
						end
					end else begin
						cmd.next_entry = 1'b1;
						state_d = wtv_pkg::ST_ENTRY;
					end
				end else if (sts.pos_last) begin
					cmd.set_found = 1'b1;
					state_d = wtv_pkg::ST_EMIT;
				end else begin
					cmd.next_pos = 1'b1;
					state_d = wtv_pkg::ST_CMPW;
				end
			end
			wtv_pkg::ST_CMPW: state_d = wtv_pkg::ST_CMP;
			wtv_pkg::ST_COPY: begin
				// buffer read at pos is valid in the cycle after pos settles
				state_d = wtv_pkg::ST_WAIT;
			end
			wtv_pkg::ST_WAIT: begin
				cmd.wr_char = 1'b1;
				if (sts.pos_last)
					state_d = wtv_pkg::ST_EMIT;
				else begin
					cmd.next_pos = 1'b1;
					state_d = wtv_pkg::ST_COPY;
				end
			end
			wtv_pkg::ST_EMIT: begin
				if (!sts.out_busy) begin
					cmd.load_out = 1'b1;
					cmd.last = last_q;
					if (!punct_q)
						cmd.clr_word = 1'b1;
					if (!punct_q && !last_q) begin
						punct_d = 1'b1;
						last_d = 1'b1;
						cmd.clr_entry = 1'b1;
						cmd.clr_pos = 1'b1;
						state_d = wtv_pkg::ST_ENTRY;
					end else begin
						punct_d = 1'b0;
						state_d = wtv_pkg::ST_IDLE;
					end
				end
			end
			default: state_d = wtv_pkg::ST_IDLE;
		endcase
	end

	property p_take_idle;
		@(posedge clk) disable iff (!arst_n)
			cmd.take_byte |-> state_q == wtv_pkg::ST_IDLE;
	endproperty
	assert property (p_take_idle) else $error("byte taken while busy");

	property p_found_emit;
		@(posedge clk) disable iff (!arst_n)
			cmd.set_found |=> state_q == wtv_pkg::ST_EMIT;
	endproperty
	assert property (p_found_emit) else $error("match did not emit");

	property p_copy_one;
		@(posedge clk) disable iff (!arst_n)
			!(cmd.wr_char && cmd.wr_len);
	endproperty
	assert property (p_copy_one) else $error("write overlap");
endmodule
`default_nettype wire

// ----- sim/testbench.sv -----
// Self-checking bench for the word tokenizer: byte stream in, vocabulary ids out.
`default_nettype none
module testbench;
	typedef struct {
		logic [7:0] ch;
		logic       eot;
		bit         pause;
		bit         quiet;
	} text_byte_t;

	typedef struct {
		logic [wtv_pkg::ID_W-1:0] id;
		logic                     is_new;
		logic                     full;
		logic                     last;
	} token_t;

	logic                         clk = 0;
	logic                         arst_n = 0;
	logic                         in_valid = 0;
	logic                         in_stall;
	logic [7:0]                   text_char = 0;
	logic                         end_of_text = 0;
	logic                         out_valid;
	logic                         out_stall = 0;
	logic [wtv_pkg::ID_W-1:0]     token_id;
	logic                         new_entry;
	logic                         table_full;
	logic                         last_of_run;

	text_byte_t text_q[$];
	token_t     token_q[$];

	// predictor state
	int    vocab_ids[string];
	int    vocab_used;
	string pending_word;

	int  errors = 0;
	int  send_gap = 0;
	int  recv_hold = 0;
	int  results_seen = 0;
	bit  long_hold_done = 0;
	bit  quiet = 0;

	word_tokenizer_vocab_ids dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.text_char(text_char), .end_of_text(end_of_text),
		.out_valid(out_valid), .out_stall(out_stall),
		.token_id(token_id), .new_entry(new_entry),
		.table_full(table_full), .last_of_run(last_of_run)
	);

	always #4 clk = ~clk;

	function automatic bit letter_or_joiner(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
			c == wtv_pkg::CH_HYPHEN || c == wtv_pkg::CH_APOS;
	endfunction

	function automatic bit punct_char(logic [7:0] c);
		return c == wtv_pkg::CH_NL || c == wtv_pkg::CH_COMMA ||
			c == wtv_pkg::CH_PERIOD || c == wtv_pkg::CH_BANG || c == wtv_pkg::CH_QMARK;
	endfunction

	function automatic void lookup_token(string tok, bit last);
		token_t t;
		t.is_new = 0;
		t.full = 0;
		t.last = last;
		if (vocab_ids.exists(tok)) begin
			t.id = wtv_pkg::ID_W'(vocab_ids[tok]);
		end else if (vocab_used < wtv_pkg::VOCAB_DEPTH) begin
			t.id = wtv_pkg::ID_W'(vocab_used);
			vocab_ids[tok] = vocab_used;
			vocab_used++;
			t.is_new = 1;
		end else begin
			t.id = 0;
			t.full = 1;
		end
		token_q.push_back(t);
	endfunction

	function automatic void tokenize_byte(logic [7:0] c, logic eot);
		string one;
		logic [7:0] lc;
		one = " ";
		lc = c;
		if (letter_or_joiner(c)) begin
			if (c >= "A" && c <= "Z")
				lc = c + 8'd32;
			one[0] = lc;
			if (pending_word.len() < wtv_pkg::MAX_TOKEN_CHARS)
				pending_word = {pending_word, one};
			if (eot) begin
				lookup_token(pending_word, 1);
				pending_word = "";
			end
		end else begin
			one[0] = c;
			if (pending_word.len() > 0) begin
				lookup_token(pending_word, !punct_char(c));
				pending_word = "";
			end
			if (punct_char(c))
				lookup_token(one, 1);
		end
	endfunction

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 0;
			text_char <= 0;
			end_of_text <= 0;
		end else begin
			if (in_valid && !in_stall)
				tokenize_byte(text_char, end_of_text);
			if (!in_valid || !in_stall) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 0;
				end else if (text_q.size() == 0) begin
					in_valid <= 0;
				end else if (text_q[0].pause) begin
					// hold until the block has drained
					in_valid <= 0;
					if (token_q.size() == 0)
						void'(text_q.pop_front());
				end else if (!quiet && $urandom_range(0, 9) == 0) begin
					send_gap = $urandom_range(0, 5);
					in_valid <= 0;
				end else begin
					text_char <= text_q[0].ch;
					end_of_text <= text_q[0].eot;
					quiet = text_q[0].quiet;
					in_valid <= 1;
					void'(text_q.pop_front());
				end
			end
		end
	end

	// receiver
	always @(posedge clk or negedge arst_n) begin
		token_t e;
		if (!arst_n) begin
			out_stall <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				results_seen++;
				if (token_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected token: id=%0d new=%b full=%b last=%b",
							token_id, new_entry, table_full, last_of_run);
				end else begin
					e = token_q.pop_front();
					if (token_id !== e.id || new_entry !== e.is_new ||
							table_full !== e.full || last_of_run !== e.last) begin
						errors++;
						if (errors <= 10)
							$display("token %0d: expected id=%0d new=%b full=%b last=%b, got id=%0d new=%b full=%b last=%b",
								results_seen, e.id, e.is_new, e.full, e.last,
								token_id, new_entry, table_full, last_of_run);
					end
				end
			end
			if (!long_hold_done && results_seen >= 40) begin
				long_hold_done = 1;
				recv_hold = 400;
			end
			if (recv_hold > 0) begin
				recv_hold--;
				out_stall <= 1;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				recv_hold = $urandom_range(0, 5);
				out_stall <= 1;
			end else begin
				out_stall <= 0;
			end
		end
	end

	task automatic add_byte(logic [7:0] c, logic eot = 0, bit q = 0);
		text_byte_t b;
		b.ch = c;
		b.eot = eot;
		b.pause = 0;
		b.quiet = q;
		text_q.push_back(b);
	endtask

	task automatic add_text(string s, bit eot_at_end = 0);
		for (int i = 0; i < s.len(); i++)
			add_byte(s[i], eot_at_end && i == s.len() - 1);
	endtask

	task automatic add_pause();
		text_byte_t b;
		b.ch = 0;
		b.eot = 0;
		b.pause = 1;
		b.quiet = 0;
		text_q.push_back(b);
	endtask

	function automatic string random_word(int len);
		string s;
		s = "";
		for (int i = 0; i < len; i++) begin
			case ($urandom_range(0, 9))
				0: s = {s, "-"};
				1: s = {s, "'"};
				2: s = {s, " "};
				default: s = {s, " "};
			endcase
			if (s[i] == " ")
				s[i] = 8'(($urandom_range(0, 1) ? "a" : "A") + $urandom_range(0, 25));
		end
		return s;
	endfunction

	initial begin
		string pool[40];
		string w;
		string sep;
		int n;
		vocab_ids["?"] = 0;
		vocab_used = 1;
		pending_word = "";

		// directed
		add_text("Hello, World!");
		add_text("?");
		add_text("don't-stop\n");
		w = "";
		repeat (60) w = {w, "z"};
		add_text({w, " "});
		add_text({w.substr(0, 48), "."});
		add_byte(8'h00);
		add_byte(8'hFF);
		add_text("ABC abc", 1);
		add_text("abc?");
		add_byte("A", 1);
		add_pause();

		// random sentences from a small word pool, some noise
		foreach (pool[i])
			pool[i] = random_word($urandom_range(1, 8));
		n = text_q.size();
		while (text_q.size() - n < 380) begin
			if ($urandom_range(0, 9) == 0) begin
				add_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
			end else begin
				w = ($urandom_range(0, 40) == 0) ? random_word($urandom_range(40, 55))
					: pool[$urandom_range(0, 39)];
				if ($urandom_range(0, 7) == 0) begin
					add_text(w, 1);
				end else begin
					case ($urandom_range(0, 7))
						0: sep = "\n";
						1: sep = ",";
						2: sep = ".";
						3: sep = "!";
						4: sep = "?";
						5: begin sep = " "; sep[0] = 8'($urandom_range(0, 255)); end
						default: sep = " ";
					endcase
					add_text({w, sep});
				end
			end
		end
		add_pause();

		// closing words, no idling from here on
		for (int k = 0; k < 10; k++) begin
			w = pool[$urandom_range(0, 39)];
			for (int i = 0; i < w.len(); i++)
				add_byte(w[i], i == w.len() - 1, 1);
		end

		repeat (11) @(posedge clk);
		arst_n <= 1;
		while (text_q.size() != 0 || in_valid || token_q.size() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
		if (errors == 0)
			$display("word_tokenizer_vocab_ids: match");
		else
			$display("word_tokenizer_vocab_ids: mismatch");
		$finish;
	end

	initial begin
		#400000000;
		$display("word_tokenizer_vocab_ids: mismatch");
		$finish;
	end
endmodule
`default_nettype wire

// ----- sim.f -----
design/wtv_pkg.sv
design/wtv_ram.sv
design/wtv_datapath.sv
design/wtv_ctrl.sv
design/word_tokenizer_vocab_ids.sv
sim/testbench.sv
